// File: hw/rtl/rems_pkg.sv
// Package for the real-time EDF/RM scheduler: table sizes, stream item layouts,
// mode codes and controller states. No dependencies.
`default_nettype none

package rems_pkg;

  localparam int unsigned READY_SLOTS   = 16;
  localparam int unsigned RELEASE_SLOTS = 16;

  localparam int unsigned RDY_IDX_W = (READY_SLOTS > 1) ? $clog2(READY_SLOTS) : 1;
  localparam int unsigned REL_IDX_W = (RELEASE_SLOTS > 1) ? $clog2(RELEASE_SLOTS) : 1;
  localparam int unsigned RDY_CNT_W = $clog2(READY_SLOTS + 1);
  localparam int unsigned REL_CNT_W = $clog2(RELEASE_SLOTS + 1);

  localparam int unsigned ID_W   = 8;
  localparam int unsigned TIME_W = 31;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    MODE_LOAD_READY   = 2'd0,
    MODE_LOAD_RELEASE = 2'd1,
    MODE_DECIDE       = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDY_SCAN,
    S_REL_SCAN,
    S_FIN_SUB,
    S_FIN_OUT
  } state_e;

  // Input tdata, lowest field last.
  typedef struct packed {
    logic [4:0]        pad;
    logic [TIME_W-1:0] cur_time;
    logic [TIME_W-1:0] rel_time;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] rem_time;
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   thread_id;
  } in_item_t;

  // Output tdata, lowest field last.
  typedef struct packed {
    logic [5:0]        pad;
    logic              table_overflow;
    logic              missed_deadline;
    logic [TIME_W-1:0] alloc_time;
    logic [ID_W-1:0]   chosen_id;
    logic              thread_valid;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] period;
  } ready_entry_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] rel_time;
    logic [TIME_W-1:0] period;
  } release_entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/rems_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rems_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/realtime_edf_rm_scheduler.sv
// Real-time EDF / RM scheduler: top level with controller and the two tables.
// Depends on rems_pkg and rems_ram.
//
// Load transfers (tuser mode 0 = ready thread, 1 = pending release) are
// accepted back to back while idle and append to a table held in a RAM with
// registered read data; a load into a full table is dropped and sets the
// overflow flag. A decide transfer (mode 2) carries the present time and
// occupies the block until its result is built (the release scan is skipped
// when a missed deadline already decides): each table has one read port, so
// the ready table is scanned one entry a cycle, with the registered read data
// and a wrap-up step behind it, then the release table the same way, then the
// subtract/compare states (S_FIN_SUB, S_FIN_OUT) build the slice. The result
// sits in an output register; loads for the next round are taken while it
// waits, a following decide stalls at the final stage until the register
// frees. After a decide both tables and the overflow flag are empty again.
// Mode 3 is accepted and ignored. The policy register (0 EDF, 1 RM) should
// only be written while no decide is in flight.
`default_nettype none

module realtime_edf_rm_scheduler (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // policy register write
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic                           cfg_data_i,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // thread_id, deadline, rem_time, period, rel_time, cur_time
  input  wire logic [rems_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // mode
  input  wire logic [1:0]                     s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // thread_valid, chosen_id, alloc_time, missed_deadline, table_overflow
  output logic [rems_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  import rems_pkg::*;

  in_item_t in_item;
  mode_e    in_mode;
  logic     in_xfer;

  assign in_item = in_item_t'(s_axis_tdata);
  assign in_mode = mode_e'(s_axis_tuser);
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Control state
  state_e               state_q, state_d;
  logic                 policy_q;
  logic [RDY_CNT_W-1:0] rdy_cnt_q, rdy_cnt_d;
  logic [REL_CNT_W-1:0] rel_cnt_q, rel_cnt_d;
  logic                 ovf_q, ovf_d;
  logic [RDY_CNT_W-1:0] rdy_ptr_q, rdy_ptr_d;
  logic [REL_CNT_W-1:0] rel_ptr_q, rel_ptr_d;
  logic                 rdy_rvld_q, rdy_rvld_d;
  logic                 rel_rvld_q, rel_rvld_d;
  logic                 out_vld_q, out_vld_d;

  // Scan accumulators (payload)
  logic [TIME_W-1:0] now_q, now_d;
  logic              miss_found_q, miss_found_d;
  logic [ID_W-1:0]   miss_id_q, miss_id_d;
  logic              best_found_q, best_found_d;
  ready_entry_t      best_q, best_d;
  logic              pre_found_q, pre_found_d;
  logic [TIME_W-1:0] pre_q, pre_d;
  logic [TIME_W-1:0] dl_left_q, dl_left_d;
  logic [TIME_W-1:0] pre_left_q, pre_left_d;
  logic              clip_q, clip_d;
  out_item_t         out_q, out_d;

  // Table RAMs. Loads are only taken in idle and scans only run after that,
  // so a write and a read never meet on the same entry.
  logic           rdy_we, rel_we;
  ready_entry_t   rdy_wdata, rdy_rdata;
  release_entry_t rel_wdata, rel_rdata;
  logic [$bits(ready_entry_t)-1:0]   rdy_rdata_raw;
  logic [$bits(release_entry_t)-1:0] rel_rdata_raw;

  assign rdy_wdata = '{id: in_item.thread_id, deadline: in_item.deadline,
                       remaining: in_item.rem_time, period: in_item.period};
  assign rel_wdata = '{id: in_item.thread_id, rel_time: in_item.rel_time,
                       period: in_item.period};
  assign rdy_rdata = ready_entry_t'(rdy_rdata_raw);
  assign rel_rdata = release_entry_t'(rel_rdata_raw);

  assign rdy_we = in_xfer && (in_mode == MODE_LOAD_READY) &&
                  (rdy_cnt_q < RDY_CNT_W'(READY_SLOTS));
  assign rel_we = in_xfer && (in_mode == MODE_LOAD_RELEASE) &&
                  (rel_cnt_q < REL_CNT_W'(RELEASE_SLOTS));

  rems_ram #(
    .WIDTH ($bits(ready_entry_t)),
    .DEPTH (READY_SLOTS)
  ) u_ready_ram (
    .clk_i   (clk_i),
    .we_i    (rdy_we),
    .waddr_i (rdy_cnt_q[RDY_IDX_W-1:0]),
    .wdata_i (rdy_wdata),
    .raddr_i (rdy_ptr_q[RDY_IDX_W-1:0]),
    .rdata_o (rdy_rdata_raw)
  );

  rems_ram #(
    .WIDTH ($bits(release_entry_t)),
    .DEPTH (RELEASE_SLOTS)
  ) u_release_ram (
    .clk_i   (clk_i),
    .we_i    (rel_we),
    .waddr_i (rel_cnt_q[REL_IDX_W-1:0]),
    .wdata_i (rel_wdata),
    .raddr_i (rel_ptr_q[REL_IDX_W-1:0]),
    .rdata_o (rel_rdata_raw)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // Per-entry compare terms
  logic              rdy_missed, rdy_better;
  logic [TIME_W-1:0] rdy_key, best_key;
  logic              rel_qualifies;
  logic [TIME_W:0]   rel_edf_key;
  logic [TIME_W-1:0] alloc_a;

  always_comb begin
    rdy_missed  = (rdy_rdata.deadline <= now_q);
    rdy_key     = policy_q ? rdy_rdata.period : rdy_rdata.deadline;
    best_key    = policy_q ? best_q.period : best_q.deadline;
    rdy_better  = !best_found_q || (rdy_key < best_key) ||
                  ((rdy_key == best_key) && (rdy_rdata.id < best_q.id));
    rel_edf_key = {1'b0, rel_rdata.rel_time} + {1'b0, rel_rdata.period};
    if (!best_found_q) begin
      rel_qualifies = 1'b1;  // idle case: every release counts
    end else if (policy_q) begin
      rel_qualifies = (rel_rdata.period < best_q.period) ||
                      ((rel_rdata.period == best_q.period) && (rel_rdata.id < best_q.id));
    end else begin
      rel_qualifies = (rel_edf_key < {1'b0, best_q.deadline}) ||
                      ((rel_edf_key == {1'b0, best_q.deadline}) &&
                       (rel_rdata.id < best_q.id));
    end
    alloc_a = (best_q.remaining < dl_left_q) ? best_q.remaining : dl_left_q;
  end

  always_comb begin
    logic [TIME_W-1:0] pre_eff;
    logic [TIME_W:0]   run_end;
    logic [TIME_W-1:0] alloc;

    state_d      = state_q;
    rdy_cnt_d    = rdy_cnt_q;
    rel_cnt_d    = rel_cnt_q;
    ovf_d        = ovf_q;
    rdy_ptr_d    = rdy_ptr_q;
    rel_ptr_d    = rel_ptr_q;
    rdy_rvld_d   = 1'b0;
    rel_rvld_d   = 1'b0;
    out_vld_d    = out_vld_q && !m_axis_tready;
    now_d        = now_q;
    miss_found_d = miss_found_q;
    miss_id_d    = miss_id_q;
    best_found_d = best_found_q;
    best_d       = best_q;
    pre_found_d  = pre_found_q;
    pre_d        = pre_q;
    dl_left_d    = dl_left_q;
    pre_left_d   = pre_left_q;
    clip_d       = clip_q;
    out_d        = out_q;
    pre_eff      = pre_found_q ? pre_q : TIME_MAX;
    run_end      = {1'b0, now_q} + {1'b0, best_q.remaining};
    alloc        = pre_left_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_mode)
            MODE_LOAD_READY: begin
              if (rdy_we) begin
                rdy_cnt_d = rdy_cnt_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            MODE_LOAD_RELEASE: begin
              if (rel_we) begin
                rel_cnt_d = rel_cnt_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            MODE_DECIDE: begin
              now_d        = in_item.cur_time;
              miss_found_d = 1'b0;
              best_found_d = 1'b0;
              pre_found_d  = 1'b0;
              rdy_ptr_d    = '0;
              rel_ptr_d    = '0;
              state_d      = S_RDY_SCAN;
            end
            default: begin
              // unused mode: dropped
            end
          endcase
        end
      end

      S_RDY_SCAN: begin
        if (rdy_ptr_q != rdy_cnt_q) begin
          rdy_ptr_d  = rdy_ptr_q + 1'b1;
          rdy_rvld_d = 1'b1;
        end
        if (rdy_rvld_q) begin
          if (rdy_missed && (!miss_found_q || (rdy_rdata.id < miss_id_q))) begin
            miss_found_d = 1'b1;
            miss_id_d    = rdy_rdata.id;
          end
          if (rdy_better) begin
            best_found_d = 1'b1;
            best_d       = rdy_rdata;
          end
        end else if (rdy_ptr_q == rdy_cnt_q) begin
          state_d = miss_found_q ? S_FIN_OUT : S_REL_SCAN;
        end
      end

      S_REL_SCAN: begin
        if (rel_ptr_q != rel_cnt_q) begin
          rel_ptr_d  = rel_ptr_q + 1'b1;
          rel_rvld_d = 1'b1;
        end
        if (rel_rvld_q) begin
          if (rel_qualifies && (!pre_found_q || (rel_rdata.rel_time < pre_q))) begin
            pre_found_d = 1'b1;
            pre_d       = rel_rdata.rel_time;
          end
        end else if (rel_ptr_q == rel_cnt_q) begin
          state_d = S_FIN_SUB;
        end
      end

      S_FIN_SUB: begin
        dl_left_d  = (best_q.deadline > now_q) ? best_q.deadline - now_q : '0;
        pre_left_d = (pre_eff > now_q) ? pre_eff - now_q : '0;
        clip_d     = pre_found_q && (run_end > {1'b0, pre_q});
        state_d    = S_FIN_OUT;
      end

      S_FIN_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          if (best_found_q) begin
            alloc = (clip_q && (pre_left_q < alloc_a)) ? pre_left_q : alloc_a;
          end
          out_d.pad            = '0;
          out_d.table_overflow = ovf_q;
          if (miss_found_q) begin
            out_d.thread_valid    = 1'b1;
            out_d.chosen_id       = miss_id_q;
            out_d.alloc_time      = '0;
            out_d.missed_deadline = 1'b1;
          end else begin
            out_d.thread_valid    = best_found_q;
            out_d.chosen_id       = best_found_q ? best_q.id : '0;
            out_d.alloc_time      = alloc;
            out_d.missed_deadline = 1'b0;
          end
          out_vld_d = 1'b1;
          rdy_cnt_d = '0;
          rel_cnt_d = '0;
          ovf_d     = 1'b0;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      policy_q   <= 1'b0;
      rdy_cnt_q  <= '0;
      rel_cnt_q  <= '0;
      ovf_q      <= 1'b0;
      rdy_ptr_q  <= '0;
      rel_ptr_q  <= '0;
      rdy_rvld_q <= 1'b0;
      rel_rvld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= cfg_data_i;
      end
      rdy_cnt_q  <= rdy_cnt_d;
      rel_cnt_q  <= rel_cnt_d;
      ovf_q      <= ovf_d;
      rdy_ptr_q  <= rdy_ptr_d;
      rel_ptr_q  <= rel_ptr_d;
      rdy_rvld_q <= rdy_rvld_d;
      rel_rvld_q <= rel_rvld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q        <= now_d;
    miss_found_q <= miss_found_d;
    miss_id_q    <= miss_id_d;
    best_found_q <= best_found_d;
    best_q       <= best_d;
    pre_found_q  <= pre_found_d;
    pre_q        <= pre_d;
    dl_left_q    <= dl_left_d;
    pre_left_q   <= pre_left_d;
    clip_q       <= clip_d;
    out_q        <= out_d;
  end

endmodule

`default_nettype wire

// File: hw/rtl/rems_checker.sv
// Port-level checker for the scheduler top level, with its bind statement.
// Depends on rems_pkg and realtime_edf_rm_scheduler.
`default_nettype none

module rems_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [1:0]                     s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [rems_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  import rems_pkg::*;

  out_item_t res;
  assign res = out_item_t'(m_axis_tdata);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a decide transfer occupies the block for at least the next cycle
  a_decide_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_DECIDE) |=> !s_axis_tready)
    else $error("input taken right after decide");

  // no thread chosen: id and missed flag are zero
  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.thread_valid |-> (res.chosen_id == '0) && !res.missed_deadline)
    else $error("idle result carries thread data");

  // missed deadline gets no time and is a valid thread
  a_missed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.missed_deadline |-> res.thread_valid && (res.alloc_time == '0))
    else $error("missed deadline result malformed");

endmodule

bind realtime_edf_rm_scheduler rems_checker u_rems_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: test/rems_grant_checker.sv
// Scoreboard for the EDF/RM scheduler: watches the policy, input and result channels,
// keeps its own copy of the thread and release tables and predicts each grant.
// Depends on rems_pkg for item layouts, table sizes and mode codes.
module rems_grant_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic                            cfg_data_i,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [rems_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]                      s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [rems_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output int unsigned                     errors_o,
  output int unsigned                     pending_o,
  output int unsigned                     grants_o,
  output int unsigned                     missed_o,
  output int unsigned                     idle_o,
  output int unsigned                     dropped_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rems_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  ready_entry_t   ready_tab [READY_SLOTS];
  release_entry_t rel_tab   [RELEASE_SLOTS];
  int             ready_n;
  int             rel_n;
  logic           load_dropped;
  logic           rate_mono;
  out_item_t      expected_grants [$];
  in_item_t       item;
  out_item_t      grant;
  int unsigned    errors, grants, missed, idle, dropped;

  function automatic logic [TIME_W-1:0] sat_diff(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // Grant for a decision at time now, from the current table contents.
  function automatic out_item_t predict_grant(input logic [TIME_W-1:0] now);
    out_item_t         g;
    int                i, late, best;
    logic [TIME_W-1:0] key, best_key, horizon, slice;
    logic [TIME_W:0]   rel_key, ref_key;
    logic              have_pre;
    g        = '0;
    late     = -1;
    best     = -1;
    best_key = '0;
    have_pre = 1'b0;
    horizon  = TIME_MAX;
    // a late thread wins outright, smallest id first
    for (i = 0; i < ready_n; i++)
      if (ready_tab[i].deadline <= now &&
          (late < 0 || ready_tab[i].id < ready_tab[late].id)) late = i;
    if (late >= 0) begin
      g.thread_valid    = 1'b1;
      g.chosen_id       = ready_tab[late].id;
      g.missed_deadline = 1'b1;
    end else begin
      for (i = 0; i < ready_n; i++) begin
        key = rate_mono ? ready_tab[i].period : ready_tab[i].deadline;
        if (best >= 0) best_key = rate_mono ? ready_tab[best].period : ready_tab[best].deadline;
        if (best < 0 || key < best_key ||
            (key == best_key && ready_tab[i].id < ready_tab[best].id)) best = i;
      end
      if (best >= 0) begin
        ref_key = {1'b0, rate_mono ? ready_tab[best].period : ready_tab[best].deadline};
        // earliest release that would preempt the pick (sums kept one bit wider)
        for (i = 0; i < rel_n; i++) begin
          rel_key = rate_mono ? {1'b0, rel_tab[i].period}
                              : {1'b0, rel_tab[i].rel_time} + {1'b0, rel_tab[i].period};
          if (rel_key < ref_key ||
              (rel_key == ref_key && rel_tab[i].id < ready_tab[best].id)) begin
            if (!have_pre || rel_tab[i].rel_time < horizon) horizon = rel_tab[i].rel_time;
            have_pre = 1'b1;
          end
        end
        slice = sat_diff(ready_tab[best].deadline, now);
        if (ready_tab[best].remaining < slice) slice = ready_tab[best].remaining;
        if (have_pre && {1'b0, now} + {1'b0, ready_tab[best].remaining} > {1'b0, horizon} &&
            sat_diff(horizon, now) < slice) slice = sat_diff(horizon, now);
        g.thread_valid = 1'b1;
        g.chosen_id    = ready_tab[best].id;
        g.alloc_time   = slice;
      end else begin
        for (i = 0; i < rel_n; i++)
          if (rel_tab[i].rel_time < horizon) horizon = rel_tab[i].rel_time;
        g.alloc_time = sat_diff(horizon, now);
      end
    end
    return g;
  endfunction

  task automatic check_grant(input out_item_t got);
    out_item_t want;
    if (expected_grants.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("[chk] %0t: result with no decision pending: valid=%0b id=%0d slice=%0d",
                 $realtime, got.thread_valid, got.chosen_id, got.alloc_time);
    end else begin
      want = expected_grants.pop_front();
      grants++;
      if (got.thread_valid !== want.thread_valid || got.chosen_id !== want.chosen_id ||
          got.alloc_time !== want.alloc_time ||
          got.missed_deadline !== want.missed_deadline ||
          got.table_overflow !== want.table_overflow) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("[chk] %0t: grant %0d exp valid=%0b id=%0d slice=%0d late=%0b drop=%0b",
                   $realtime, grants, want.thread_valid, want.chosen_id,
                   want.alloc_time, want.missed_deadline, want.table_overflow);
          $display("[chk]              got valid=%0b id=%0d slice=%0d late=%0b drop=%0b",
                   got.thread_valid, got.chosen_id, got.alloc_time,
                   got.missed_deadline, got.table_overflow);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_n      = 0;
      rel_n        = 0;
      load_dropped = 1'b0;
      rate_mono    = 1'b0;
      expected_grants.delete();
    end else begin
      // results first: a result never belongs to a decision taken at the same edge
      if (m_axis_tvalid && m_axis_tready) check_grant(out_item_t'(m_axis_tdata));
      if (cfg_valid_i && cfg_ready_i) rate_mono = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        item = in_item_t'(s_axis_tdata);
        case (s_axis_tuser)
          MODE_LOAD_READY: begin
            if (ready_n < int'(READY_SLOTS)) begin
              ready_tab[ready_n] = '{id: item.thread_id, deadline: item.deadline,
                                     remaining: item.rem_time, period: item.period};
              ready_n++;
            end else begin
              load_dropped = 1'b1;
            end
          end
          MODE_LOAD_RELEASE: begin
            if (rel_n < int'(RELEASE_SLOTS)) begin
              rel_tab[rel_n] = '{id: item.thread_id, rel_time: item.rel_time,
                                 period: item.period};
              rel_n++;
            end else begin
              load_dropped = 1'b1;
            end
          end
          MODE_DECIDE: begin
            grant                = predict_grant(item.cur_time);
            grant.table_overflow = load_dropped;
            if (grant.missed_deadline) missed++;
            if (!grant.thread_valid) idle++;
            if (grant.table_overflow) dropped++;
            expected_grants.push_back(grant);
            ready_n      = 0;
            rel_n        = 0;
            load_dropped = 1'b0;
          end
          default: ;
        endcase
      end
    end
    errors_o  <= errors;
    pending_o <= expected_grants.size();
    grants_o  <= grants;
    missed_o  <= missed;
    idle_o    <= idle;
    dropped_o <= dropped;
  end

endmodule

// File: test/tb_top.sv
// Top of the EDF/RM scheduler testbench: clock, reset, stimulus, result sink and verdict.
// Depends on rems_pkg, realtime_edf_rm_scheduler and rems_grant_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rems_pkg::*;

  localparam logic       POLICY_EDF   = 1'b0;
  localparam logic       POLICY_RM    = 1'b1;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;  // accepted and dropped by the block
  localparam int         DRAIN_CYCLES = 48;    // drain wait, longer than the slowest decide
  localparam int         LONG_HOLD    = 300;   // receiver hold-off for back-pressure
  localparam int         PHASE_ITEMS  = 125;   // items per random phase, four phases

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_data      = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int unsigned errors, pending, grants, missed, idle, dropped;
  int unsigned stim_items;     // accepted items, ignored mode excluded
  int unsigned squeeze_asked;  // bumped by stimulus, served by the result sink
  bit          sender_steady;  // no gaps on the input side for the current round

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  realtime_edf_rm_scheduler uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rems_grant_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors_o      (errors),
    .pending_o     (pending),
    .grants_o      (grants),
    .missed_o      (missed),
    .idle_o        (idle),
    .dropped_o     (dropped)
  );

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned draw_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    else if (roll < 85) return $urandom_range(3, 1);
    else if (roll < 97) return $urandom_range(12, 4);
    else return $urandom_range(60, 20);
  endfunction

  // base + offset in [lo, hi], clamped into the 31-bit time range
  function automatic logic [TIME_W-1:0] near(input logic [TIME_W-1:0] base,
                                             input int lo, input int hi);
    longint v;
    v = longint'(base) + lo + longint'($urandom_range(hi - lo));
    if (v < 0) v = 0;
    else if (v > longint'(TIME_MAX)) v = longint'(TIME_MAX);
    return v[TIME_W-1:0];
  endfunction

  // Every field wide random; callers overwrite the fields that matter.
  function automatic in_item_t noise_item();
    in_item_t it;
    it           = '0;
    it.thread_id = ID_W'($urandom());
    it.deadline  = TIME_W'($urandom());
    it.rem_time  = TIME_W'($urandom());
    it.period    = TIME_W'($urandom());
    it.rel_time  = TIME_W'($urandom());
    it.cur_time  = TIME_W'($urandom());
    return it;
  endfunction

  // Present time, with both ends of the range reached regularly so that
  // deadlines clamp at zero and release+period sums run past the top.
  function automatic logic [TIME_W-1:0] pick_now();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return TIME_W'($urandom_range(60));
    else if (roll == 1) return TIME_MAX - TIME_W'($urandom_range(60));
    else return TIME_W'($urandom_range(32'h7FFF_F000, 32'h1000));
  endfunction

  // Crowded rounds draw from a tiny id pool so ties and repeated ids are common.
  function automatic logic [ID_W-1:0] pick_id(input bit crowded);
    return crowded ? ID_W'($urandom_range(3)) : ID_W'($urandom_range(255));
  endfunction

  function automatic logic [TIME_W-1:0] pick_period(input bit crowded);
    int unsigned roll;
    roll = $urandom_range(19);
    if (roll == 0) return TIME_MAX;
    else if (roll < 3) return TIME_W'($urandom_range(32'h7FFF_FFFF, 1));
    else if (crowded) return TIME_W'(5 << $urandom_range(3));
    else return TIME_W'($urandom_range(500, 1));
  endfunction

  function automatic logic [TIME_W-1:0] pick_remaining();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return TIME_W'($urandom());
    else if (roll == 1) return '0;
    else return TIME_W'($urandom_range(300));
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // One input transfer. Called at a rising edge; returns at the edge where it was
  // taken, with tvalid left high so back-to-back transfers need no toggle.
  task automatic send_item(input logic [1:0] mode, input in_item_t it);
    int unsigned gap;
    gap = sender_steady ? 0 : draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (mode != MODE_UNUSED) stim_items++;
  endtask

  // Directed transfer with the fields spelled out.
  task automatic put(input logic [1:0] mode, input logic [ID_W-1:0] id,
                     input logic [TIME_W-1:0] dl, input logic [TIME_W-1:0] rem,
                     input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] rel,
                     input logic [TIME_W-1:0] now);
    in_item_t it;
    it           = '0;
    it.thread_id = id;
    it.deadline  = dl;
    it.rem_time  = rem;
    it.period    = per;
    it.rel_time  = rel;
    it.cur_time  = now;
    send_item(mode, it);
  endtask

  // Stop offering, wait out every pending grant, then let the block go quiet:
  // the policy may only change with nothing in flight.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_policy(input logic rm);
    cfg_valid <= 1'b1;
    cfg_data  <= rm;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One scheduling round: loads in random order around a common present time,
  // an occasional ignored item, then the decision itself.
  task automatic run_round(input int n_ready, input int n_release, input bit crowded);
    logic [TIME_W-1:0] now;
    in_item_t          it;
    int                left_r, left_l, late_lo;
    now     = pick_now();
    left_r  = n_ready;
    left_l  = n_release;
    late_lo = ($urandom_range(7) == 0) ? -200 : -8;  // some rounds lean toward late threads
    while (left_r + left_l > 0) begin
      it = noise_item();
      if (left_l == 0 || (left_r > 0 && $urandom_range(left_r + left_l - 1) < left_r)) begin
        it.thread_id = pick_id(crowded);
        it.deadline  = near(now, late_lo, 500);
        it.rem_time  = pick_remaining();
        it.period    = pick_period(crowded);
        send_item(MODE_LOAD_READY, it);
        left_r--;
      end else begin
        it.thread_id = pick_id(crowded);
        it.rel_time  = near(now, -30, 600);
        it.period    = pick_period(crowded);
        send_item(MODE_LOAD_RELEASE, it);
        left_l--;
      end
      if ($urandom_range(49) == 0) send_item(MODE_UNUSED, noise_item());
    end
    it          = noise_item();
    it.cur_time = now;
    send_item(MODE_DECIDE, it);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, steady stretches, and a long hold-off on request
  // so the output register and the stalled decide behind it back up the input.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left, steady_left, hold_left, squeeze_done, roll;
    logic        rdy;
    stall_left   = 0;
    steady_left  = 0;
    hold_left    = 0;
    squeeze_done = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (squeeze_asked > squeeze_done) begin
        squeeze_done++;
        hold_left = LONG_HOLD - 1;
        rdy       = 1'b0;
      end else if (steady_left > 0) begin
        steady_left--;
        rdy = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        roll = $urandom_range(99);
        rdy  = 1'b1;
        if (roll < 8) begin
          steady_left = $urandom_range(150, 50);
        end else if (roll < 40) begin
          stall_left = draw_gap();
          rdy        = (stall_left == 0);
        end
      end
      m_axis_tready <= rdy;
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int          k, roll;
    int unsigned target;
    bit          crowded;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, earliest deadline first ---
    write_policy(POLICY_EDF);
    // empty tables: idle until the time ceiling, from both ends of the clock
    put(MODE_DECIDE, 8'd0, '0, '0, '0, '0, '0);
    put(MODE_DECIDE, 8'd0, '0, '0, '0, '0, TIME_MAX);
    // two late threads (one exactly at its deadline): smaller id wins, zero slice
    put(MODE_LOAD_READY, 8'd5, 31'd100, 31'd10, 31'd50, '0, '0);
    put(MODE_LOAD_READY, 8'd3, 31'd80, 31'd5, 31'd40, '0, '0);
    put(MODE_LOAD_READY, 8'd4, 31'd20, 31'd7, 31'd30, '0, '0);
    put(MODE_LOAD_READY, 8'd2, 31'd50, 31'd9, 31'd60, '0, '0);
    put(MODE_DECIDE, 8'd0, '0, '0, '0, '0, 31'd50);
    // preempting releases, one by a tie on the deadline broken by id
    put(MODE_LOAD_READY, 8'd7, 31'd1000, 31'd500, 31'd200, '0, '0);
    put(MODE_LOAD_RELEASE, 8'd9, '0, '0, 31'd300, 31'd100, '0);
    put(MODE_LOAD_RELEASE, 8'd1, '0, '0, 31'd950, 31'd50, '0);
    put(MODE_DECIDE, 8'd0, '0, '0, '0, '0, 31'd10);
    // preempting release already in the past clips the slice to zero;
    // an item of the unused mode sits in the middle
    put(MODE_LOAD_READY, 8'd0, TIME_MAX, TIME_MAX, 31'd5, '0, '0);
    put(MODE_LOAD_RELEASE, 8'd0, '0, '0, 31'd1, 31'd3, '0);
    put(MODE_UNUSED, 8'd255, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX);
    put(MODE_DECIDE, 8'd0, '0, '0, '0, '0, 31'd20);
    // no ready thread: idle until the earliest release
    put(MODE_LOAD_RELEASE, 8'd255, '0, '0, TIME_MAX, TIME_MAX, '0);
    put(MODE_LOAD_RELEASE, 8'd6, '0, '0, 31'd40, 31'd500, '0);
    put(MODE_DECIDE, 8'd0, '0, '0, '0, '0, 31'd100);

    // --- directed, rate monotonic: period tie by id, release with equal period ---
    settle();
    write_policy(POLICY_RM);
    put(MODE_LOAD_READY, 8'd3, 31'd300, 31'd1000, 31'd20, '0, '0);
    put(MODE_LOAD_READY, 8'd1, 31'd200, 31'd50, 31'd20, '0, '0);
    put(MODE_LOAD_RELEASE, 8'd0, '0, '0, 31'd20, 31'd90, '0);
    put(MODE_LOAD_RELEASE, 8'd9, '0, '0, 31'd25, 31'd70, '0);
    put(MODE_DECIDE, 8'd0, '0, '0, '0, '0, 31'd60);

    // --- random rounds, policy alternating per phase; even phases start with a
    // long receiver hold-off while the sender keeps offering ---
    for (k = 0; k < 4; k++) begin
      settle();
      write_policy((k % 2 == 0) ? POLICY_EDF : POLICY_RM);
      if (k % 2 == 0) squeeze_asked <= squeeze_asked + 1;
      target = stim_items + PHASE_ITEMS;
      while (stim_items < target) begin
        sender_steady = ($urandom_range(4) == 0);
        crowded       = ($urandom_range(2) == 0);
        roll          = $urandom_range(19);
        if (roll == 0) run_round($urandom_range(20, 17), $urandom_range(4), crowded);
        else if (roll == 1) run_round($urandom_range(4), $urandom_range(20, 17), crowded);
        else if (roll == 2) run_round(0, $urandom_range(5), crowded);
        else if (roll == 3) run_round(0, 0, crowded);
        else run_round($urandom_range(6, 1), $urandom_range(6), crowded);
      end
      sender_steady = 1'b0;
    end

    settle();
    $display("covered %0d input items and %0d grants under both EDF and RM policies",
             stim_items, grants);
    $display("  of which %0d late-thread picks, %0d idle grants, %0d with dropped loads",
             missed, idle, dropped);
    if (errors == 0 && pending == 0) begin
      $display("realtime_edf_rm_scheduler: match");
    end else begin
      $display("realtime_edf_rm_scheduler: mismatch");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d grants still pending", pending);
    $display("realtime_edf_rm_scheduler: mismatch");
    $finish;
  end

endmodule
